// ----- rtl/core/asep_pkg.sv -----
// Shared types, constants and helpers for the arc segment end pose block.
// No dependencies; every other file refers to this package by scoped names.

package asep_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 20;

	// exact restoring divider: one quotient bit per stage
	localparam int DIV_STEPS = 32 + FRAC_BITS;
	localparam int DIV_W     = DIV_STEPS;
	localparam int Q_W       = DIV_W + 1;
	localparam int H_W       = Q_W + 1;
	localparam int SAT_W     = 68;
	localparam int RND_SHIFT = 30 - FRAC_BITS;

	// angle conversion stage, rotation steps, quadrant fold
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// register file: one register, word index taken from paddr[2]
	localparam int   ADDR_W    = 3;
	localparam logic REG_LIMIT = 1'b0;

	localparam logic [30:0] LIMIT_RESET = 31'd65536;

	localparam logic [63:0] INV_TWO_PI   = 64'h28BE60DB9391054A;
	localparam logic [63:0] INV_TWO_PI_F = INV_TWO_PI >> FRAC_BITS;
	localparam logic [31:0] K_LO         = INV_TWO_PI[31:0];
	localparam logic [31:0] K_HI         = INV_TWO_PI[63:32];
	localparam logic [63:0] QUARTER_FWD  = 64'h4000000000000000;
	localparam logic [63:0] QUARTER_BACK = 64'hC000000000000000;

	localparam logic [32:0]        TWO_PI_Q30  = 33'd6746518852;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic signed [66:0] HALF_Q30    = 67'sd536870912;

	localparam logic signed [SAT_W-1:0] S32_MAX = 68'sd2147483647;
	localparam logic signed [SAT_W-1:0] S32_MIN = -68'sd2147483648;

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} quad_t;

	// one classified segment as it waits between front and back
	typedef struct packed {
		logic signed [31:0] x0;
		logic signed [31:0] y0;
		logic signed [31:0] th;
		logic signed [31:0] ds;
		logic [31:0]        rmag;
		logic [31:0]        dmag;
		logic               straight;
		logic               qneg;
		logic               rpos;
		logic signed [31:0] rev_len;
	} asep_item_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:    v = 30'd843314857;
			5'd1:    v = 30'd497837829;
			5'd2:    v = 30'd263043837;
			5'd3:    v = 30'd133525159;
			5'd4:    v = 30'd67021687;
			5'd5:    v = 30'd33543516;
			5'd6:    v = 30'd16775851;
			5'd7:    v = 30'd8388437;
			5'd8:    v = 30'd4194283;
			5'd9:    v = 30'd2097149;
			5'd10:   v = 30'd1048576;
			5'd11:   v = 30'd524288;
			5'd12:   v = 30'd262144;
			5'd13:   v = 30'd131072;
			5'd14:   v = 30'd65536;
			5'd15:   v = 30'd32768;
			5'd16:   v = 30'd16384;
			5'd17:   v = 30'd8192;
			5'd18:   v = 30'd4096;
			5'd19:   v = 30'd2048;
			5'd20:   v = 30'd1024;
			5'd21:   v = 30'd512;
			5'd22:   v = 30'd256;
			5'd23:   v = 30'd128;
			5'd24:   v = 30'd64;
			5'd25:   v = 30'd32;
			5'd26:   v = 30'd16;
			5'd27:   v = 30'd8;
			5'd28:   v = 30'd4;
			5'd29:   v = 30'd2;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) begin
			r = 32'sh7FFFFFFF;
		end else if (v < S32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/asep_front.sv -----
// Front end: limit register behind the APB port, input beat acceptance and
// segment classification (straight or arc, magnitudes, signs). Uses asep_pkg.

module asep_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [asep_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [31:0]         start_x,
	input  logic signed [31:0]         start_y,
	input  logic signed [31:0]         start_heading,
	input  logic signed [31:0]         seg_length,
	input  logic signed [31:0]         turn_radius,
	input  logic                       q_full,
	output logic                       q_push,
	output asep_pkg::asep_item_t       q_item
);

	logic [30:0] limit_q;
	logic [31:0] rmag;
	logic [31:0] dmag;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= asep_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == asep_pkg::REG_LIMIT) begin
			limit_q <= pwdata[30:0];
		end
	end

	always_comb begin
		if (paddr[2] == asep_pkg::REG_LIMIT) begin
			prdata = {1'b0, limit_q};
		end else begin
			prdata = 32'd0;
		end
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// most negative value maps to 2^31 in the unsigned magnitude
	always_comb begin
		if (turn_radius[31]) begin
			rmag = -turn_radius;
		end else begin
			rmag = turn_radius;
		end
		if (seg_length[31]) begin
			dmag = -seg_length;
		end else begin
			dmag = seg_length;
		end
	end

	always_comb begin
		q_item.x0       = start_x;
		q_item.y0       = start_y;
		q_item.th       = start_heading;
		q_item.ds       = seg_length;
		q_item.rmag     = rmag;
		q_item.dmag     = dmag;
		q_item.straight = (turn_radius == 32'sd0) || (rmag < {1'b0, limit_q});
		q_item.qneg     = seg_length[31] ^ turn_radius[31];
		q_item.rpos     = !turn_radius[31];
		if (seg_length == 32'sh80000000) begin
			q_item.rev_len = 32'sh7FFFFFFF;
		end else begin
			q_item.rev_len = -seg_length;
		end
	end

endmodule

// ----- rtl/core/asep_fifo.sv -----
// Short queue of classified segments between front and back.
// Depends on asep_pkg for the item type and depth.

module asep_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  asep_pkg::asep_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output asep_pkg::asep_item_t pop_item
);

	asep_pkg::asep_item_t mem_q [asep_pkg::FIFO_DEPTH];

	logic [asep_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [asep_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [asep_pkg::FIFO_AW:0]   cnt_q;

	assign full      = cnt_q == (asep_pkg::FIFO_AW+1)'(asep_pkg::FIFO_DEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/asep_cordic.sv -----
// Pipelined rotation-mode CORDIC: turn phase in, Q30 cosine and sine out;
// the pipe advances only while en is high. Depends on asep_pkg.

module asep_cordic (
	input  logic               clk,
	input  logic               en,
	input  logic [63:0]        phase,
	output logic signed [31:0] cos_val,
	output logic signed [31:0] sin_val
);

	logic signed [31:0] cx_s [asep_pkg::CORDIC_STEPS+1];
	logic signed [31:0] cy_s [asep_pkg::CORDIC_STEPS+1];
	logic signed [31:0] cz_s [asep_pkg::CORDIC_STEPS+1];
	asep_pkg::quad_t    cq_s [asep_pkg::CORDIC_STEPS+1];
	logic [62:0]        zprod;

	// quadrant remainder to a Q30 angle in [0, pi/2)
	assign zprod = phase[61:32] * asep_pkg::TWO_PI_Q30;

	always_ff @(posedge clk) begin
		if (en) begin
			cq_s[0] <= asep_pkg::quad_t'(phase[63:62]);
			cz_s[0] <= signed'({1'b0, zprod[62:32]});
			cx_s[0] <= asep_pkg::CORDIC_GAIN;
			cy_s[0] <= 32'sd0;
		end
	end

	for (genvar i = 0; i < asep_pkg::CORDIC_STEPS; i++) begin : g_step
		logic signed [31:0] ang;
		assign ang = signed'({2'b00, asep_pkg::atan_q30(5'(i))});
		always_ff @(posedge clk) begin
			if (en) begin
				cq_s[i+1] <= cq_s[i];
				if (!cz_s[i][31]) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - ang;
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + ang;
				end
			end
		end
	end

	// fold back into the full circle
	always_ff @(posedge clk) begin
		if (en) begin
			case (cq_s[asep_pkg::CORDIC_STEPS])
				asep_pkg::QUAD_0: begin
					cos_val <= cx_s[asep_pkg::CORDIC_STEPS];
					sin_val <= cy_s[asep_pkg::CORDIC_STEPS];
				end
				asep_pkg::QUAD_1: begin
					cos_val <= -cy_s[asep_pkg::CORDIC_STEPS];
					sin_val <= cx_s[asep_pkg::CORDIC_STEPS];
				end
				asep_pkg::QUAD_2: begin
					cos_val <= -cx_s[asep_pkg::CORDIC_STEPS];
					sin_val <= -cy_s[asep_pkg::CORDIC_STEPS];
				end
				default: begin
					cos_val <= cy_s[asep_pkg::CORDIC_STEPS];
					sin_val <= -cx_s[asep_pkg::CORDIC_STEPS];
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/asep_back.sv -----
// Back end: divider, phase build, two CORDICs, scaling and saturation,
// all under one stall enable. Uses asep_pkg and asep_cordic.

module asep_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  asep_pkg::asep_item_t q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   end_x,
	output logic signed [31:0]   end_y,
	output logic signed [31:0]   end_heading,
	output logic signed [31:0]   reversed_length
);

	typedef struct packed {
		logic signed [31:0] x0;
		logic signed [31:0] y0;
		logic signed [31:0] ds;
		logic [31:0]        rmag;
		logic signed [31:0] hd;
		logic signed [31:0] rev_len;
		logic               straight;
	} side_t;

	logic adv;

	// divider pipeline
	logic [asep_pkg::DIV_STEPS:0]   dvld_s;
	asep_pkg::asep_item_t           ditem_s [asep_pkg::DIV_STEPS+1];
	logic [asep_pkg::DIV_W-1:0]     dnum_s  [asep_pkg::DIV_STEPS+1];
	logic [31:0]                    drem_s  [asep_pkg::DIV_STEPS+1];

	logic                           v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	asep_pkg::asep_item_t           it_s1, it_s2, it_s3, it_s4;
	logic signed [asep_pkg::Q_W-1:0] q_s1;
	logic signed [31:0]             hd_s2, hd_s3, hd_s4;
	logic [63:0]                    pa0_s2, pa1_s2, pc0_s2, pc1_s2;
	logic [31:0]                    pb0_s2, pb1_s2;
	logic                           sg0_s2, sg1_s2;
	logic [63:0]                    ph0_s3, phq_s3;
	logic [63:0]                    pha_s4, phb_s4;

	logic [asep_pkg::CORDIC_LAT-1:0] sv_s;
	side_t                          sd_s [asep_pkg::CORDIC_LAT];
	side_t                          side_s4;
	logic signed [31:0]             c1, s1, c2, s2;

	side_t                          side_s5, side_s6, side_s7;
	logic signed [32:0]             mc_s5, ms_s5, mul_s5;
	logic signed [65:0]             px_s6, py_s6;
	logic signed [66:0]             rx_s7, ry_s7;
	logic signed [31:0]             end_x_s8, end_y_s8, end_hd_s8, rev_len_s8;

	// hold the whole pipe while the output register waits
	assign adv   = !v_s8 || out_ready;
	assign q_pop = adv && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_s <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			sv_s   <= '0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
		end else if (adv) begin
			dvld_s <= {dvld_s[asep_pkg::DIV_STEPS-1:0], q_valid};
			v_s1   <= dvld_s[asep_pkg::DIV_STEPS];
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			sv_s   <= {sv_s[asep_pkg::CORDIC_LAT-2:0], v_s4};
			v_s5   <= sv_s[asep_pkg::CORDIC_LAT-1];
			v_s6   <= v_s5;
			v_s7   <= v_s6;
			v_s8   <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ditem_s[0] <= q_item;
			dnum_s[0]  <= {q_item.dmag, {asep_pkg::FRAC_BITS{1'b0}}};
			drem_s[0]  <= 32'd0;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < asep_pkg::DIV_STEPS; k++) begin : g_div
		logic [32:0] trial;
		logic [32:0] diff;
		logic        ge;
		assign trial = {drem_s[k], dnum_s[k][asep_pkg::DIV_W-1]};
		assign diff  = trial - {1'b0, ditem_s[k].rmag};
		assign ge    = trial >= {1'b0, ditem_s[k].rmag};
		always_ff @(posedge clk) begin
			if (adv) begin
				ditem_s[k+1] <= ditem_s[k];
				dnum_s[k+1]  <= {dnum_s[k][asep_pkg::DIV_W-2:0], ge};
				drem_s[k+1]  <= ge ? diff[31:0] : trial[31:0];
			end
		end
	end

	// s1: apply the quotient sign
	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1 <= ditem_s[asep_pkg::DIV_STEPS];
			if (ditem_s[asep_pkg::DIV_STEPS].qneg) begin
				q_s1 <= -signed'({1'b0, dnum_s[asep_pkg::DIV_STEPS]});
			end else begin
				q_s1 <= signed'({1'b0, dnum_s[asep_pkg::DIV_STEPS]});
			end
		end
	end

	// s2: heading sum and turn-phase partial products
	logic signed [asep_pkg::H_W-1:0] hsum;
	logic [31:0]                     w0, w1;
	logic signed [asep_pkg::Q_W-1:0] wq;
	logic [asep_pkg::FRAC_BITS-1:0]  fr0, fr1;

	always_comb begin
		hsum = asep_pkg::H_W'(it_s1.th) + asep_pkg::H_W'(q_s1);
		w0   = 32'(it_s1.th >>> asep_pkg::FRAC_BITS);
		wq   = q_s1 >>> asep_pkg::FRAC_BITS;
		w1   = wq[31:0];
		fr0  = it_s1.th[asep_pkg::FRAC_BITS-1:0];
		fr1  = q_s1[asep_pkg::FRAC_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s2 <= it_s1;
			if (it_s1.straight) begin
				hd_s2 <= it_s1.th;
			end else begin
				hd_s2 <= asep_pkg::sat32(asep_pkg::SAT_W'(hsum));
			end
			pa0_s2 <= {32'd0, w0} * {32'd0, asep_pkg::K_LO};
			pb0_s2 <= w0 * asep_pkg::K_HI;
			pc0_s2 <= {{(64-asep_pkg::FRAC_BITS){1'b0}}, fr0} * asep_pkg::INV_TWO_PI_F;
			sg0_s2 <= it_s1.th[31];
			pa1_s2 <= {32'd0, w1} * {32'd0, asep_pkg::K_LO};
			pb1_s2 <= w1 * asep_pkg::K_HI;
			pc1_s2 <= {{(64-asep_pkg::FRAC_BITS){1'b0}}, fr1} * asep_pkg::INV_TWO_PI_F;
			sg1_s2 <= q_s1[asep_pkg::Q_W-1];
		end
	end

	// s3: sum partials modulo a full turn; a negative whole part adds -K_LO above bit 32
	logic [31:0] hi0, hi1;
	always_comb begin
		hi0 = pb0_s2 - (sg0_s2 ? asep_pkg::K_LO : 32'd0);
		hi1 = pb1_s2 - (sg1_s2 ? asep_pkg::K_LO : 32'd0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s3  <= it_s2;
			hd_s3  <= hd_s2;
			ph0_s3 <= pa0_s2 + {hi0, 32'd0} + pc0_s2;
			phq_s3 <= pa1_s2 + {hi1, 32'd0} + pc1_s2;
		end
	end

	// s4: shift by a quarter turn toward the center, add the swept angle
	logic [63:0] phs;
	always_comb begin
		phs = ph0_s3 + (it_s3.rpos ? asep_pkg::QUARTER_BACK : asep_pkg::QUARTER_FWD);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s4  <= it_s3;
			hd_s4  <= hd_s3;
			pha_s4 <= it_s3.straight ? ph0_s3 : phs;
			phb_s4 <= phs + phq_s3;
		end
	end

	asep_cordic u_cordic_a (
		.clk     (clk),
		.en      (adv),
		.phase   (pha_s4),
		.cos_val (c1),
		.sin_val (s1)
	);

	asep_cordic u_cordic_b (
		.clk     (clk),
		.en      (adv),
		.phase   (phb_s4),
		.cos_val (c2),
		.sin_val (s2)
	);

	always_comb begin
		side_s4.x0       = it_s4.x0;
		side_s4.y0       = it_s4.y0;
		side_s4.ds       = it_s4.ds;
		side_s4.rmag     = it_s4.rmag;
		side_s4.hd       = hd_s4;
		side_s4.rev_len  = it_s4.rev_len;
		side_s4.straight = it_s4.straight;
	end

	// sideband delay matching the CORDIC latency
	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s[0] <= side_s4;
			for (int j = 1; j < asep_pkg::CORDIC_LAT; j++) begin
				sd_s[j] <= sd_s[j-1];
			end
		end
	end

	// s5: pick the operands for the scaling multiply
	side_t              sdo;
	logic signed [32:0] mc, ms, mul;
	always_comb begin
		sdo = sd_s[asep_pkg::CORDIC_LAT-1];
		if (sdo.straight) begin
			mc  = 33'(c1);
			ms  = 33'(s1);
			mul = 33'(sdo.ds);
		end else begin
			mc  = 33'(c2) - 33'(c1);
			ms  = 33'(s2) - 33'(s1);
			mul = signed'({1'b0, sdo.rmag});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= sdo;
			mc_s5   <= mc;
			ms_s5   <= ms;
			mul_s5  <= mul;
		end
	end

	// s6: multiply
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s6 <= side_s5;
			px_s6   <= mc_s5 * mul_s5;
			py_s6   <= ms_s5 * mul_s5;
		end
	end

	// s7: add HALF_Q30, then arithmetic shift right by RND_SHIFT
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s7 <= side_s6;
			rx_s7   <= (67'(px_s6) + asep_pkg::HALF_Q30) >>> asep_pkg::RND_SHIFT;
			ry_s7   <= (67'(py_s6) + asep_pkg::HALF_Q30) >>> asep_pkg::RND_SHIFT;
		end
	end

	// s8: offset by start point and saturate into the output register
	always_ff @(posedge clk) begin
		if (adv) begin
			end_x_s8   <= asep_pkg::sat32(asep_pkg::SAT_W'(rx_s7) +
				asep_pkg::SAT_W'(side_s7.x0));
			end_y_s8   <= asep_pkg::sat32(asep_pkg::SAT_W'(ry_s7) +
				asep_pkg::SAT_W'(side_s7.y0));
			end_hd_s8  <= side_s7.hd;
			rev_len_s8 <= side_s7.rev_len;
		end
	end

	assign out_valid       = v_s8;
	assign end_x           = end_x_s8;
	assign end_y           = end_y_s8;
	assign end_heading     = end_hd_s8;
	assign reversed_length = rev_len_s8;

endmodule

// ----- rtl/core/arc_segment_end_pose.sv -----
// Top level of the arc segment end pose block: front, queue and back.
// Depends on asep_pkg, asep_front, asep_fifo, asep_back.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one segment per beat: start pose,
//   signed length and signed turn radius, all signed Q15.16. Output channel
//   (out_valid/out_ready) returns one beat per segment: end pose, end heading
//   and negated length, saturated to the signed 32-bit range, in input order.
//   The APB port holds straight_radius_limit at byte address 0; write it only
//   while no segment is in flight.
// Structure: the 48-stage divider, the phase build, two parallel 22-stage
//   CORDIC pipes and the scaling multiply.
// Throughput: one segment per cycle while out_ready stays high.
// Reset: clears all valid state and loads the limit with 1.0 (65536).
// Stall: while a result waits and out_ready is low, the back pipeline holds;
//   the four-entry queue keeps taking beats until it fills, then in_ready drops.

module arc_segment_end_pose (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [asep_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [31:0]         start_x,
	input  logic signed [31:0]         start_y,
	input  logic signed [31:0]         start_heading,
	input  logic signed [31:0]         seg_length,
	input  logic signed [31:0]         turn_radius,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [31:0]         end_x,
	output logic signed [31:0]         end_y,
	output logic signed [31:0]         end_heading,
	output logic signed [31:0]         reversed_length
);

	asep_pkg::asep_item_t push_item;
	asep_pkg::asep_item_t pop_item;
	logic                 q_push;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_valid;

	asep_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.start_x       (start_x),
		.start_y       (start_y),
		.start_heading (start_heading),
		.seg_length    (seg_length),
		.turn_radius   (turn_radius),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	asep_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_item  (pop_item)
	);

	asep_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_item          (pop_item),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.end_x           (end_x),
		.end_y           (end_y),
		.end_heading     (end_heading),
		.reversed_length (reversed_length)
	);

endmodule

// ----- rtl/core/asep_checker.sv -----
// Port-level checks for arc_segment_end_pose, attached by bind.
// Depends on asep_pkg and the top level's port list.

module asep_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [asep_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                 pwdata,
	input logic [31:0]                 prdata,
	input logic                        pready,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic signed [31:0]          end_x,
	input logic signed [31:0]          end_y,
	input logic signed [31:0]          end_heading,
	input logic signed [31:0]          reversed_length
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(end_x) && $stable(end_y) &&
		$stable(end_heading) && $stable(reversed_length))
		else $error("result beat changed while stalled");

	// the edge after a reset edge shows no result beat
	a_no_out_in_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result beat during reset");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	a_limit_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == asep_pkg::REG_LIMIT |=>
		paddr[2] != asep_pkg::REG_LIMIT || prdata == {1'b0, $past(pwdata[30:0])})
		else $error("limit register readback mismatch");

	a_prdata_msb: assert property (@(posedge clk) disable iff (!arst_n) !prdata[31])
		else $error("unused register bit set");

endmodule

bind arc_segment_end_pose asep_checker u_asep_checker (.*);

// ----- test/arc_segment_end_pose_tb.sv -----
// Self-checking bench for arc_segment_end_pose: drives segments with random gaps,
// predicts every end pose in a scoreboard and compares each output beat in order.
// Depends on asep_pkg and the arc_segment_end_pose RTL.
`timescale 1ns / 100ps

module arc_segment_end_pose_tb;

	localparam int      ITEMS_PER_PHASE = 190;
	localparam longint  CYCLE_LIMIT     = 2000000;
	localparam bit [63:0] TURN_PER_RAD  = 64'h28BE60DB9391054A;
	localparam bit [63:0] RAD_TO_Q30    = 64'd6746518852;
	localparam bit [63:0] QUARTER       = 64'h4000000000000000;
	localparam logic [asep_pkg::ADDR_W-1:0] LIMIT_ADDR = 3'd0;
	localparam logic [asep_pkg::ADDR_W-1:0] SPARE_ADDR = 3'd4;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] hdg;
		logic signed [31:0] len;
		logic signed [31:0] rad;
	} seg_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] hdg;
		logic signed [31:0] rev;
	} pose_t;

	class pose_scoreboard;
		longint unsigned limit;
		pose_t           poses[$];
		int              errors;

		function new();
			limit  = 65536;
			errors = 0;
		endfunction

		function bit [63:0] to_phase(longint v);
			bit [63:0] fr;
			longint    whole;
			fr    = 64'(v) & ((64'd1 << asep_pkg::FRAC_BITS) - 64'd1);
			whole = v >>> asep_pkg::FRAC_BITS;
			return 64'(whole) * TURN_PER_RAD + fr * (TURN_PER_RAD >> asep_pkg::FRAC_BITS);
		endfunction

		function void rotate(bit [63:0] ph, output longint c, output longint s);
			longint    tbl[30];
			longint    x, y, z, dx, dy;
			bit [63:0] rem;
			tbl = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
				16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
				65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
				16, 8, 4, 2};
			rem = {2'b00, ph[61:0]};
			z   = longint'(((rem >> 32) * RAD_TO_Q30) >> 32);
			x   = asep_pkg::CORDIC_GAIN;
			y   = 0;
			for (int i = 0; i < asep_pkg::CORDIC_STEPS && i < 30; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= tbl[i];
				end else begin
					x += dx; y -= dy; z += tbl[i];
				end
			end
			case (asep_pkg::quad_t'(ph[63:62]))
				asep_pkg::QUAD_0: begin c = x;  s = y;  end
				asep_pkg::QUAD_1: begin c = -y; s = x;  end
				asep_pkg::QUAD_2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
		endfunction

		function longint round_q30(longint p);
			return (p + (64'sd1 <<< 29)) >>> (30 - asep_pkg::FRAC_BITS);
		endfunction

		function logic signed [31:0] clip(longint v);
			if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
			if (v < -64'sd2147483648) return 32'sh80000000;
			return v[31:0];
		endfunction

		function void note_segment(seg_t sg);
			longint    x0, y0, th, ds, r, rmag, dmag, qm, q, c1, s1, c2, s2;
			bit [63:0] ph0, phs;
			pose_t     p;
			x0   = sg.x;
			y0   = sg.y;
			th   = sg.hdg;
			ds   = sg.len;
			r    = sg.rad;
			rmag = r < 0 ? -r : r;
			ph0  = to_phase(th);
			if (r == 0 || rmag < longint'(limit)) begin
				rotate(ph0, c1, s1);
				p.x   = clip(x0 + round_q30(c1 * ds));
				p.y   = clip(y0 + round_q30(s1 * ds));
				p.hdg = clip(th);
			end else begin
				dmag = ds < 0 ? -ds : ds;
				qm   = (dmag <<< asep_pkg::FRAC_BITS) / rmag;
				q    = ((ds < 0) != (r < 0)) ? -qm : qm;
				phs  = (r > 0) ? ph0 - QUARTER : ph0 + QUARTER;
				rotate(phs, c1, s1);
				rotate(phs + to_phase(q), c2, s2);
				p.x   = clip(x0 + round_q30(rmag * (c2 - c1)));
				p.y   = clip(y0 + round_q30(rmag * (s2 - s1)));
				p.hdg = clip(th + q);
			end
			p.rev = clip(-ds);
			poses.push_back(p);
		endfunction

		function void check_pose(pose_t got);
			pose_t e;
			if (poses.size() == 0) begin
				$error("output beat with no segment pending");
				errors++;
				return;
			end
			e = poses.pop_front();
			if (got.x !== e.x) begin
				$error("end_x: expected %h, got %h", e.x, got.x); errors++;
			end
			if (got.y !== e.y) begin
				$error("end_y: expected %h, got %h", e.y, got.y); errors++;
			end
			if (got.hdg !== e.hdg) begin
				$error("end_heading: expected %h, got %h", e.hdg, got.hdg); errors++;
			end
			if (got.rev !== e.rev) begin
				$error("reversed_length: expected %h, got %h", e.rev, got.rev); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [asep_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] start_x = '0, start_y = '0, start_heading = '0;
	logic signed [31:0] seg_length = '0, turn_radius = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] end_x, end_y, end_heading, reversed_length;

	pose_scoreboard sb = new();
	longint cycles = 0;
	int     n_out = 0;
	int     stall_left = 0;
	bit     long_hold_done = 1'b0;

	arc_segment_end_pose dut (.*);

	always #6 clk = ~clk;

	// every third hundred of results runs with no idling on either side
	function automatic bit quiet();
		return (n_out / 100) % 3 == 1;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("arc_segment_end_pose: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		pose_t got;
		seg_t  sg;
		if (arst_n && in_valid && in_ready) begin
			sg = '{start_x, start_y, start_heading, seg_length, turn_radius};
			sb.note_segment(sg);
		end
		if (arst_n && out_valid && out_ready) begin
			got = '{end_x, end_y, end_heading, reversed_length};
			sb.check_pose(got);
			n_out <= n_out + 1;
		end
	end

	// receiver: short and long stalls, plus one long hold-off to fill the block
	always @(posedge clk) begin
		int r;
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready  <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				out_ready <= 1'b1;
				if (!long_hold_done && n_out >= 300) begin
					long_hold_done <= 1'b1;
					stall_left     <= 400;
				end else if (!quiet() && r < 20) begin
					stall_left <= $urandom_range(1, 3);
				end else if (!quiet() && r < 22) begin
					stall_left <= $urandom_range(10, 40);
				end
			end
		end
	end

	function automatic logic [31:0] rnd_word();
		logic [31:0] picks[5];
		picks = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h1, 32'hFFFFFFFF};
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return picks[$urandom_range(0, 4)];
			default: return 32'(signed'(int'($urandom_range(0, 2 ** 24)) >>>
				$urandom_range(0, 16)) * ($urandom_range(0, 1) ? 1 : -1));
		endcase
	endfunction

	task automatic apb_write(logic [asep_pkg::ADDR_W-1:0] addr, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == LIMIT_ADDR) sb.limit = data[30:0];
	endtask

	// hold the beat until taken, then optionally drop valid for a gap
	task automatic push_segment(seg_t sg, int gap);
		in_valid      <= 1'b1;
		start_x       <= sg.x;
		start_y       <= sg.y;
		start_heading <= sg.hdg;
		seg_length    <= sg.len;
		turn_radius   <= sg.rad;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.poses.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet() || r < 70) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	initial begin
		seg_t   dir[$];
		seg_t   sg;
		logic [31:0] limits[5];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		dir = '{
			'{0, 0, 0, 32'sh00010000, 0},
			'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 32'sh7FFFFFFF, 0},
			'{32'sh80000000, 32'sh80000000, 32'sh0003243F, 32'sh80000000, 0},
			'{0, 0, 32'sh7FFFFFFF, 32'sh00050000, 32'sh00008000},
			'{0, 0, 32'sh80000000, 32'sh00050000, 32'shFFFF8000},
			'{32'sh00100000, 32'shFFF00000, 0, 32'sh00030000, 32'sh00020000},
			'{32'sh00100000, 32'shFFF00000, 0, 32'sh00030000, 32'shFFFE0000},
			'{0, 0, 32'sh00019220, 32'shFFFD0000, 32'sh00020000},
			'{0, 0, 32'sh00019220, 32'shFFFD0000, 32'shFFFE0000},
			'{0, 0, 0, 32'sh00010000, 32'sh80000000},
			'{0, 0, 0, 32'sh80000000, 32'sh80000000},
			'{0, 0, 0, 32'sh80000000, 32'sh7FFFFFFF},
			'{0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh00010000},
			'{0, 0, 32'sh80000000, 32'sh80000000, 32'sh00010000},
			'{32'sh7FFFFFFF, 0, 0, 32'sh7FFFFFFF, 32'sh00010000},
			'{0, 0, 32'sh00064880, 32'sh00010000, 32'sh0000FFFF},
			'{0, 0, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'sh00010001},
			'{32'sh12345678, 32'shEDCBA987, 32'sh000C90FD, 0, 32'sh00100000}
		};
		foreach (dir[i]) push_segment(dir[i], pick_gap());
		drain();

		// zero limit, then spare address (ignored), high bit dropped, max, random
		limits = '{32'h0, 32'h80010000, 32'hFFFFFFFF, 32'h0, 32'h0};
		limits[3] = $urandom;
		limits[4] = $urandom_range(0, 32'h00400000);
		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 1) apb_write(SPARE_ADDR, 32'h00000005);
			apb_write(LIMIT_ADDR, limits[ph]);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				sg.x   = rnd_word();
				sg.y   = rnd_word();
				sg.hdg = rnd_word();
				sg.len = rnd_word();
				sg.rad = ($urandom_range(0, 9) == 0) ? 32'sh0 : rnd_word();
				push_segment(sg, pick_gap());
			end
			drain();
		end

		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.poses.size() == 0) begin
			$display("arc_segment_end_pose: match");
		end else begin
			$display("arc_segment_end_pose: mismatch");
		end
		$finish;
	end

endmodule
